// File: src/ptt_pkg.sv
// shared types, codes and defaults for the priority ordered task table
`timescale 1ns / 1ps
package ptt_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int NAME_BITS_DEF = 64;

  // command kinds
  localparam logic [2:0] KIND_INSERT   = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_KILL     = 3'd2;
  localparam logic [2:0] KIND_CHANGE   = 3'd3;
  localparam logic [2:0] KIND_FIND     = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         slot;
    logic signed [15:0] priority_req;
    logic [63:0]        name_key;
    logic [7:0]         task_id;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot_out;
    logic [7:0] task_out;
    logic [3:0] count;
    logic       last;
  } rsp_word_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_cmd_t;

endpackage

// File: src/ptt_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/ptt_free_list.sv
// circular free slot queue kept in ram, unwritten entries read as their own index
`timescale 1ns / 1ps
module ptt_free_list #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ptt_pkg::fl_cmd_t             cmd,
  input  logic [$clog2(NUM_SLOTS)-1:0] push_slot,
  output logic [$clog2(NUM_SLOTS)-1:0] head_slot,
  output logic                         empty
);
  import ptt_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int TW = CW + 1;

  logic [SW-1:0]        head;
  logic [CW-1:0]        fill;
  logic [NUM_SLOTS-1:0] written;
  logic [TW-1:0]        tail_sum;
  logic [SW-1:0]        tail;
  logic                 do_push;
  logic [SW-1:0]        ram_q;
  logic [SW-1:0]        head_q;
  logic                 written_q;

  assign tail_sum = TW'(head) + TW'(fill);
  assign tail     = (tail_sum >= TW'(NUM_SLOTS)) ? SW'(tail_sum - TW'(NUM_SLOTS))
                                                  : SW'(tail_sum);
  assign do_push  = cmd.push && (fill < CW'(NUM_SLOTS));
  assign empty    = (fill == '0);
  assign head_slot = written_q ? ram_q : head_q;

  ptt_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail),
    .wdata (push_slot),
    .raddr (head),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    head_q    <= head;
    written_q <= written[head];
    if (rst) begin
      head    <= '0;
      fill    <= CW'(NUM_SLOTS);
      written <= '0;
    end else begin
      if (cmd.pop) begin
        head <= (head == SW'(NUM_SLOTS - 1)) ? '0 : head + SW'(1);
      end
      if (do_push) begin
        written[tail] <= 1'b1;
      end
      if (cmd.pop && !do_push) begin
        fill <= fill - CW'(1);
      end else if (do_push && !cmd.pop) begin
        fill <= fill + CW'(1);
      end
    end
  end

endmodule

// File: src/priority_ordered_task_table.sv
// top level: command sequencer over slot data, run order and free list memories
// kill and change need no walk; insert scans the run order, then shifts the entries behind it
// find scans the run order; dispatch visits every entry and can be held by output stalls
// one command at a time; the next is taken once the last word of this one is registered
// the run order walk does one memory read per step
// reset (synchronous) empties the run list and refills the free list with slots in order
`timescale 1ns / 1ps
module priority_ordered_task_table #(
  parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEF,
  parameter int NAME_BITS = ptt_pkg::NAME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  ptt_pkg::cmd_word_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ptt_pkg::rsp_word_t rsp
);
  import ptt_pkg::*;

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int DW = 24 + NAME_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_START   = 4'd1;
  localparam logic [3:0] S_INS_A   = 4'd2;
  localparam logic [3:0] S_INS_CHK = 4'd3;
  localparam logic [3:0] S_INS_R2  = 4'd4;
  localparam logic [3:0] S_INS_R3  = 4'd5;
  localparam logic [3:0] S_INS_SH  = 4'd6;
  localparam logic [3:0] S_INS_SW  = 4'd7;
  localparam logic [3:0] S_DSP_A   = 4'd8;
  localparam logic [3:0] S_DSP_B   = 4'd9;
  localparam logic [3:0] S_DSP_C   = 4'd10;
  localparam logic [3:0] S_DSP_FIN = 4'd11;
  localparam logic [3:0] S_FND_CHK = 4'd12;
  localparam logic [3:0] S_FND_R2  = 4'd13;
  localparam logic [3:0] S_FND_R3  = 4'd14;
  localparam logic [3:0] S_EMIT    = 4'd15;

  logic [3:0] state;

  // latched command
  logic [2:0]           op_kind;
  logic [2:0]           op_slot;
  logic signed [15:0]   op_prio;
  logic [NAME_BITS-1:0] op_name;
  logic [7:0]           op_task;

  // list bookkeeping
  logic [CW-1:0]        run_length;
  logic [CW-1:0]        idx;
  logic [CW-1:0]        pos;
  logic [CW-1:0]        shift_ix;
  logic [CW-1:0]        keep;
  logic [CW-1:0]        visited;
  logic [SW-1:0]        cur_slot;
  logic [SW-1:0]        new_slot;
  logic [NUM_SLOTS-1:0] killed;
  logic [NUM_SLOTS-1:0] in_list;

  rsp_word_t res_word;

  // memory ports
  logic          ro_we;
  logic [SW-1:0] ro_waddr;
  logic [SW-1:0] ro_wdata;
  logic [SW-1:0] ro_raddr;
  logic [SW-1:0] ro_rdata;
  logic          sd_we;
  logic [SW-1:0] sd_waddr;
  logic [SW-1:0] sd_raddr;
  logic [DW-1:0] sd_rdata;
  logic [DW-1:0] sd_wdata;

  fl_cmd_t       fl_cmd;
  logic [SW-1:0] fl_head;
  logic          fl_empty;

  logic               out_free;
  logic               emit_en;
  rsp_word_t          emit_word;
  rsp_word_t          start_word;
  logic               ins_full;
  logic [SW-1:0]      slot_ix;
  logic               slot_hit;
  logic               dsp_dead;
  logic signed [15:0] rd_prio;
  logic [7:0]         rd_task;
  logic [NAME_BITS-1:0] rd_name;

  assign cmd_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign slot_ix  = SW'(op_slot);
  assign slot_hit = (int'(op_slot) < NUM_SLOTS) && in_list[slot_ix];
  assign dsp_dead = killed[cur_slot];
  assign ins_full = fl_empty || (run_length >= CW'(NUM_SLOTS));

  // slot data word: priority, task, name
  assign rd_prio  = sd_rdata[DW-1 -: 16];
  assign rd_task  = sd_rdata[NAME_BITS +: 8];
  assign rd_name  = sd_rdata[NAME_BITS-1:0];
  assign sd_wdata = {op_prio, op_task, op_name};

  ptt_ram #(.WIDTH(SW), .DEPTH(NUM_SLOTS)) u_run_order (
    .clk   (clk),
    .we    (ro_we),
    .waddr (ro_waddr),
    .wdata (ro_wdata),
    .raddr (ro_raddr),
    .rdata (ro_rdata)
  );

  ptt_ram #(.WIDTH(DW), .DEPTH(NUM_SLOTS)) u_slot_data (
    .clk   (clk),
    .we    (sd_we),
    .waddr (sd_waddr),
    .wdata (sd_wdata),
    .raddr (sd_raddr),
    .rdata (sd_rdata)
  );

  ptt_free_list #(.NUM_SLOTS(NUM_SLOTS)) u_free_list (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fl_cmd),
    .push_slot (cur_slot),
    .head_slot (fl_head),
    .empty     (fl_empty)
  );

  // run order port: shifting reads one below the write point, otherwise walk index
  always_comb begin
    ro_raddr = (state == S_INS_SH) ? SW'(shift_ix - CW'(1)) : idx[SW-1:0];
    ro_we    = 1'b0;
    ro_waddr = idx[SW-1:0];
    ro_wdata = cur_slot;
    if (state == S_INS_SW) begin
      ro_we    = 1'b1;
      ro_waddr = shift_ix[SW-1:0];
      ro_wdata = ro_rdata;
    end else if (state == S_INS_SH && shift_ix == pos) begin
      ro_we    = 1'b1;
      ro_waddr = pos[SW-1:0];
      ro_wdata = new_slot;
    end else if (state == S_DSP_C && !dsp_dead && out_free) begin
      // compaction: live entries move down over removed ones
      ro_we    = 1'b1;
      ro_waddr = keep[SW-1:0];
      ro_wdata = cur_slot;
    end
  end

  // slot data port: address follows the run order read right after it lands
  always_comb begin
    if (state == S_INS_R2 || state == S_DSP_B || state == S_FND_R2) begin
      sd_raddr = ro_rdata;
    end else begin
      sd_raddr = cur_slot;
    end
    sd_we    = 1'b0;
    sd_waddr = slot_ix;
    if (state == S_INS_A) begin
      sd_we    = 1'b1;
      sd_waddr = fl_head;
    end else if (state == S_START && op_kind == KIND_CHANGE && slot_hit) begin
      sd_we = 1'b1;
    end
  end

  always_comb begin
    fl_cmd.pop  = (state == S_INS_A);
    fl_cmd.push = (state == S_DSP_C) && dsp_dead;
  end

  // word prepared when a command starts, final for full inserts and for kill and change
  always_comb begin
    start_word      = '0;
    start_word.last = 1'b1;
    case (op_kind) inside
      KIND_INSERT: begin
        if (ins_full) begin
          start_word.status = ST_FULL;
        end
      end
      KIND_KILL, KIND_CHANGE: begin
        if (!slot_hit) begin
          start_word.status = ST_NOTFOUND;
        end else begin
          start_word.slot_out = op_slot;
          if (op_kind == KIND_CHANGE) begin
            start_word.task_out = op_task;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result words
  always_comb begin
    emit_en   = 1'b0;
    emit_word = res_word;
    unique case (state)
      S_EMIT: begin
        emit_en = out_free;
      end
      S_DSP_C: begin
        emit_en            = out_free && !dsp_dead;
        emit_word.status   = ST_OK;
        emit_word.slot_out = 3'(cur_slot);
        emit_word.task_out = rd_task;
        emit_word.count    = '0;
        emit_word.last     = 1'b0;
      end
      S_DSP_FIN: begin
        emit_en            = out_free;
        emit_word.status   = ST_OK;
        emit_word.slot_out = '0;
        emit_word.task_out = '0;
        emit_word.count    = 4'(visited);
        emit_word.last     = 1'b1;
      end
      default: begin
        emit_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      rsp <= emit_word;
    end
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_en) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      op_kind <= cmd.kind;
      op_slot <= cmd.slot;
      op_prio <= cmd.priority_req;
      op_name <= cmd.name_key[NAME_BITS-1:0];
      op_task <= cmd.task_id;
    end
    if (state == S_INS_R2 || state == S_DSP_B || state == S_FND_R2) begin
      cur_slot <= ro_rdata;
    end
    if (rst) begin
      state      <= S_IDLE;
      run_length <= '0;
      killed     <= '0;
      in_list    <= '0;
      idx        <= '0;
      pos        <= '0;
      shift_ix   <= '0;
      keep       <= '0;
      visited    <= '0;
      new_slot   <= '0;
      res_word   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_START;
          end
        end
        S_START: begin
          idx      <= '0;
          res_word <= start_word;
          case (op_kind) inside
            KIND_INSERT: begin
              state <= ins_full ? S_EMIT : S_INS_A;
            end
            KIND_DISPATCH: begin
              visited <= run_length;
              keep    <= '0;
              state   <= (run_length == '0) ? S_DSP_FIN : S_DSP_A;
            end
            KIND_KILL, KIND_CHANGE: begin
              state <= S_EMIT;
              if (slot_hit) begin
                // kill marks the slot, change clears the mark
                killed[slot_ix] <= (op_kind == KIND_KILL);
              end
            end
            KIND_FIND: begin
              state <= S_FND_CHK;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_INS_A: begin
          new_slot         <= fl_head;
          killed[fl_head]  <= 1'b0;
          in_list[fl_head] <= 1'b1;
          state            <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (idx == run_length) begin
            pos      <= idx;
            shift_ix <= run_length;
            state    <= S_INS_SH;
          end else begin
            state <= S_INS_R2;
          end
        end
        S_INS_R2: begin
          state <= S_INS_R3;
        end
        S_INS_R3: begin
          if (rd_prio > op_prio) begin
            pos      <= idx;
            shift_ix <= run_length;
            state    <= S_INS_SH;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_INS_CHK;
          end
        end
        S_INS_SH: begin
          if (shift_ix == pos) begin
            run_length <= run_length + CW'(1);
            res_word   <= '{status: ST_OK, slot_out: 3'(new_slot), task_out: op_task,
                            count: 4'd0, last: 1'b1};
            state      <= S_EMIT;
          end else begin
            state <= S_INS_SW;
          end
        end
        S_INS_SW: begin
          shift_ix <= shift_ix - CW'(1);
          state    <= S_INS_SH;
        end
        S_DSP_A: begin
          state <= S_DSP_B;
        end
        S_DSP_B: begin
          state <= S_DSP_C;
        end
        S_DSP_C: begin
          if (dsp_dead || out_free) begin
            if (dsp_dead) begin
              // silent removal, slot goes back to the free list tail
              killed[cur_slot]  <= 1'b0;
              in_list[cur_slot] <= 1'b0;
            end else begin
              keep <= keep + CW'(1);
            end
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) == visited) ? S_DSP_FIN : S_DSP_A;
          end
        end
        S_DSP_FIN: begin
          if (out_free) begin
            run_length <= keep;
            state      <= S_IDLE;
          end
        end
        S_FND_CHK: begin
          if (idx == run_length) begin
            res_word.status <= ST_NOTFOUND;
            state           <= S_EMIT;
          end else begin
            state <= S_FND_R2;
          end
        end
        S_FND_R2: begin
          state <= S_FND_R3;
        end
        S_FND_R3: begin
          if (rd_name == op_name) begin
            res_word <= '{status: ST_OK, slot_out: 3'(cur_slot), task_out: rd_task,
                          count: 4'd0, last: 1'b1};
            state    <= S_EMIT;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_FND_CHK;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
